FILE: design/tcpct_pkg.sv
// ----------------------------------------------------------------------------
// tcpct_pkg: shared types and constants of the TCP connection table
// Item layouts, status codes, connection states and controller/datapath links.
// ----------------------------------------------------------------------------
package tcpct_pkg;

    localparam int Entries = 16;
    localparam int IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
    localparam int CntW    = $clog2(Entries + 1);

    localparam logic [15:0] MinHeaderBytes = 16'd20;
    localparam logic [7:0]  FlagSyn = 8'h02;
    localparam logic [7:0]  FlagPsh = 8'h08;
    localparam logic [7:0]  FlagAck = 8'h10;

    localparam logic [1:0] OpRecv  = 2'd0;
    localparam logic [1:0] OpOpen  = 2'd1;
    localparam logic [1:0] OpClose = 2'd2;
    localparam logic [1:0] OpSend  = 2'd3;

    localparam logic [1:0] StClosed  = 2'd0;
    localparam logic [1:0] StListen  = 2'd1;
    localparam logic [1:0] StSynRcvd = 2'd2;
    localparam logic [1:0] StEstab   = 2'd3;

    localparam logic [3:0] StsIgnored   = 4'd0;
    localparam logic [3:0] StsTooShort  = 4'd1;
    localparam logic [3:0] StsUnknown   = 4'd2;
    localparam logic [3:0] StsSynack    = 4'd3;
    localparam logic [3:0] StsEstab     = 4'd4;
    localparam logic [3:0] StsData      = 4'd5;
    localparam logic [3:0] StsNoPayload = 4'd6;
    localparam logic [3:0] StsListening = 4'd8;
    localparam logic [3:0] StsFull      = 4'd9;
    localparam logic [3:0] StsClosed    = 4'd10;
    localparam logic [3:0] StsSent      = 4'd11;
    localparam logic [3:0] StsNotEstab  = 4'd12;
    localparam logic [3:0] StsBadIndex  = 4'd13;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [7:0]  flags;
        logic [3:0]  header_words;
        logic [15:0] segment_length;
        logic [3:0]  entry_index;
        logic [15:0] send_length;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  entry_used;
        logic        segment_sent;
        logic [7:0]  tx_flags;
        logic [31:0] tx_remote_ip;
        logic [15:0] tx_src_port;
        logic [15:0] tx_dst_port;
        logic [31:0] tx_seq;
        logic [31:0] tx_ack;
        logic [15:0] payload_length;
        logic [5:0]  payload_offset;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic            load;      // capture the item
        logic            rd;        // read entry rd_idx, compare results next cycle
        logic [IdxW-1:0] rd_idx;
        logic            act;       // apply the update to entry act_idx, emit result
        logic [IdxW-1:0] act_idx;
        logic            found;     // act_idx is valid
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       short_seg;
        logic       bad_idx;
        logic       hit_exact;      // compare of the entry read last cycle
        logic       hit_listen;
        logic       is_closed;
    } t_sts;

endpackage

FILE: design/tcpct_datapath.sv
// ----------------------------------------------------------------------------
// tcpct_datapath: entry store, item register and result builder
// Holds the table in one memory read one entry per cycle by the controller.
// ----------------------------------------------------------------------------
module tcpct_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcpct_pkg::t_in_item i_item,
    input  tcpct_pkg::t_ctl     i_ctl,
    output tcpct_pkg::t_sts     o_sts,
    output logic                o_done,
    output tcpct_pkg::t_out_item o_result
);
    import tcpct_pkg::*;

    typedef struct packed {
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [15:0] own_port;
        logic [31:0] nseq;
        logic [31:0] eack;
    } t_entry;

    t_entry     r_mem [Entries];
    logic [1:0] r_state [Entries];
    logic       r_valid [Entries];   // entry written since reset
    t_in_item   r_item;
    t_entry     r_rd;
    logic [1:0] r_rd_st;
    logic       r_done;
    t_out_item  r_res;

    t_entry    w_rd;
    t_entry    n_ent;
    logic      n_we;
    logic [1:0] n_st;
    logic      n_st_we;
    t_out_item n_res;
    logic [15:0] w_hlen;
    logic [IdxW-1:0] w_ai;
    logic [IdxW-1:0] w_ri;
    logic            w_fixed;

    // close and send address the entry named by the item itself
    assign w_fixed = r_item.op == OpClose || r_item.op == OpSend;
    assign w_hlen = {10'd0, r_item.header_words, 2'b00};
    assign w_ai   = w_fixed ? IdxW'(r_item.entry_index) : i_ctl.act_idx;
    assign w_ri   = w_fixed ? IdxW'(r_item.entry_index) : i_ctl.rd_idx;
    assign w_rd   = r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_item <= '0;
        else if (i_ctl.load) r_item <= i_item;
        if (i_ctl.rd) begin
            r_rd    <= r_valid[w_ri] ? r_mem[w_ri] : '0;
            r_rd_st <= r_state[w_ri];
        end
        if (n_we) r_mem[w_ai] <= n_ent;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Entries; i++) begin
                r_state[i] <= StClosed;
                r_valid[i] <= 1'b0;
            end
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.act;
            if (n_st_we) r_state[w_ai] <= n_st;
            if (n_we) r_valid[w_ai] <= 1'b1;
        end
    end

    always_comb begin
        o_sts.op         = r_item.op;
        o_sts.short_seg  = r_item.segment_length < MinHeaderBytes;
        o_sts.bad_idx    = {28'd0, r_item.entry_index} >= 32'(Entries);
        o_sts.is_closed  = r_rd_st == StClosed;
        o_sts.hit_exact  = r_rd_st != StClosed && w_rd.peer_addr == r_item.src_addr
                         && w_rd.peer_port == r_item.src_port
                         && w_rd.own_port == r_item.dst_port;
        o_sts.hit_listen = r_rd_st == StListen && w_rd.own_port == r_item.dst_port;
    end

    // entry w_rd is the one at act_idx when act is raised (read the cycle before)
    always_comb begin
        n_ent   = w_rd;
        n_we    = 1'b0;
        n_st    = r_rd_st;
        n_st_we = 1'b0;
        n_res   = '0;
        n_res.entry_used = 4'(w_ai);
        if (i_ctl.act) begin
            unique case (r_item.op)
                OpRecv: begin
                    if (r_item.segment_length < MinHeaderBytes) begin
                        n_res.status = StsTooShort;
                        n_res.entry_used = '0;
                    end else if (!i_ctl.found) begin
                        n_res.status = StsUnknown;
                        n_res.entry_used = '0;
                    end else begin
                        unique case (r_rd_st)
                            StListen: begin
                                if ((r_item.flags & FlagSyn) != 8'd0) begin
                                    n_ent.peer_addr = r_item.src_addr;
                                    n_ent.peer_port = r_item.src_port;
                                    n_ent.eack = r_item.seq_number + 32'd1;
                                    n_ent.nseq = '0;
                                    n_we = 1'b1;
                                    n_st = StSynRcvd;
                                    n_st_we = 1'b1;
                                    n_res.status = StsSynack;
                                    n_res.segment_sent = 1'b1;
                                    n_res.tx_flags = FlagSyn | FlagAck;
                                    n_res.tx_remote_ip = r_item.src_addr;
                                    n_res.tx_src_port = w_rd.own_port;
                                    n_res.tx_dst_port = r_item.src_port;
                                    n_res.tx_seq = '0;
                                    n_res.tx_ack = r_item.seq_number + 32'd1;
                                end else begin
                                    n_res.status = StsIgnored;
                                end
                            end
                            StSynRcvd: begin
                                if ((r_item.flags & FlagAck) != 8'd0 &&
                                    r_item.ack_number == w_rd.nseq + 32'd1) begin
                                    n_ent.nseq = w_rd.nseq + 32'd1;
                                    n_we = 1'b1;
                                    n_st = StEstab;
                                    n_st_we = 1'b1;
                                    n_res.status = StsEstab;
                                end else begin
                                    n_res.status = StsIgnored;
                                end
                            end
                            StEstab: begin
                                if (w_hlen >= r_item.segment_length) begin
                                    n_res.status = StsNoPayload;
                                end else begin
                                    n_res.status = StsData;
                                    n_res.payload_length = r_item.segment_length - w_hlen;
                                    n_res.payload_offset = w_hlen[5:0];
                                end
                            end
                            default: n_res.status = StsIgnored;
                        endcase
                    end
                end
                OpOpen: begin
                    if (!i_ctl.found) begin
                        n_res.status = StsFull;
                        n_res.entry_used = '0;
                    end else begin
                        n_ent = '0;
                        n_ent.own_port = r_item.dst_port;
                        n_we = 1'b1;
                        n_st = StListen;
                        n_st_we = 1'b1;
                        n_res.status = StsListening;
                    end
                end
                OpClose: begin
                    n_res.entry_used = r_item.entry_index;
                    if (o_sts.bad_idx) begin
                        n_res.status = StsBadIndex;
                    end else begin
                        n_st = StClosed;
                        n_st_we = 1'b1;
                        n_res.status = StsClosed;
                    end
                end
                OpSend: begin
                    n_res.entry_used = r_item.entry_index;
                    if (o_sts.bad_idx) begin
                        n_res.status = StsBadIndex;
                    end else if (r_rd_st != StEstab) begin
                        n_res.status = StsNotEstab;
                    end else begin
                        n_ent.nseq = w_rd.nseq + {16'd0, r_item.send_length};
                        n_we = 1'b1;
                        n_res.status = StsSent;
                        n_res.segment_sent = 1'b1;
                        n_res.tx_flags = FlagAck | FlagPsh;
                        n_res.tx_remote_ip = w_rd.peer_addr;
                        n_res.tx_src_port = w_rd.own_port;
                        n_res.tx_dst_port = w_rd.peer_port;
                        n_res.tx_seq = w_rd.nseq;
                        n_res.tx_ack = w_rd.eack;
                        n_res.payload_length = r_item.send_length;
                    end
                end
                default: n_res.status = StsIgnored;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_st_only_on_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_st_we |-> i_ctl.act) else $error("state write without action");
    a_done_follows_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.act |=> o_done) else $error("result not issued after action");
    a_sent_has_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.segment_sent |-> o_result.tx_flags != 8'd0)
        else $error("header sent without flags");
`endif
endmodule

FILE: design/tcpct_ctrl.sv
// ----------------------------------------------------------------------------
// tcpct_ctrl: sequencer of the connection table
// Walks entries one a cycle for receive/open matches, then issues the update.
// ----------------------------------------------------------------------------
module tcpct_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tcpct_pkg::t_sts i_sts,
    input  logic            i_done,
    output tcpct_pkg::t_ctl o_ctl,
    output logic            o_busy
);
    import tcpct_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN, S_REREAD, S_ACT, S_WAIT}
        t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;         // entries read so far
    logic            r_pass, n_pass;       // 0 exact match, 1 listener
    logic            r_found, n_found;
    logic [IdxW-1:0] r_idx, n_idx;
    logic [IdxW-1:0] w_prev;
    logic            w_hit;

    assign w_prev = IdxW'(r_cnt - CntW'(1));

    always_comb begin
        unique case (i_sts.op)
            OpRecv:  w_hit = r_pass ? i_sts.hit_listen : i_sts.hit_exact;
            OpOpen:  w_hit = i_sts.is_closed;
            default: w_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pass  = r_pass;
        n_found = r_found;
        n_idx   = r_idx;
        o_ctl   = '0;
        o_ctl.rd_idx  = r_cnt[IdxW-1:0];
        o_ctl.act_idx = r_idx;
        o_ctl.found   = r_found;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.load = i_start;
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_cnt = '0; n_pass = 1'b0; n_found = 1'b0; n_idx = '0;
                if (i_sts.op == OpRecv && i_sts.short_seg) begin
                    n_state = S_ACT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue a read of entry r_cnt, check the previous one
                if (r_cnt != '0 && w_hit) begin
                    n_found = 1'b1;
                    n_idx   = w_prev;
                    n_state = S_REREAD;
                end else if (i_sts.op == OpClose || i_sts.op == OpSend) begin
                    n_state = S_REREAD;
                end else if (r_cnt == CntW'(Entries)) begin
                    if (i_sts.op == OpRecv && !r_pass) begin
                        n_pass = 1'b1;
                        n_cnt  = '0;
                    end else begin
                        n_state = S_ACT;
                    end
                end else begin
                    o_ctl.rd = 1'b1;
                    n_cnt = r_cnt + CntW'(1);
                end
            end
            S_REREAD: begin
                o_ctl.rd = 1'b1;
                o_ctl.rd_idx = r_idx;
                n_state = S_ACT;
            end
            S_ACT: begin
                o_ctl.act = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0; r_pass <= 1'b0; r_found <= 1'b0; r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt; r_pass <= n_pass; r_found <= n_found; r_idx <= n_idx;
        end
    end

    assign o_busy = r_state != S_IDLE;
endmodule

FILE: design/tcp_connection_table_handshake.sv
// ----------------------------------------------------------------------------
// tcp_connection_table_handshake: passive-open TCP connection table
// Sequencer plus entry store; one command in, one result out.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item and raise start while busy is low; the item is taken at
//   that edge and busy stays high until its result has been issued.
//   The result appears on o_result for exactly one cycle with o_valid high,
//   the last cycle of busy; the receiver cannot stall, so it must take it then.
// Sequence:
//   One table entry is read per cycle through a single memory read port.
//   A receive walks the entries for an exact match and then for a listener,
//   stopping at the first hit; an open walks them for a closed entry; close
//   and send read the named entry directly, and a short segment skips the walk.
// Throughput:
//   Items are processed one at a time; busy drops after the result, so the
//   next item is taken in the cycle after the result at the earliest.
// Reset:
//   Synchronous active-low reset marks every entry closed and unwritten;
//   an unwritten entry reads as all zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module tcp_connection_table_handshake (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tcpct_pkg::t_in_item   i_item,
    output logic                  o_valid,
    output tcpct_pkg::t_out_item  o_result
);
    import tcpct_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_done;

    tcpct_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_sts(w_sts),
        .i_done(w_done), .o_ctl(w_ctl), .o_busy(busy)
    );

    tcpct_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_ctl(w_ctl),
        .o_sts(w_sts), .o_done(w_done), .o_result(o_result)
    );

    assign o_valid = w_done;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("item accepted but not busy");
    a_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside busy window");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result repeated");
`endif
endmodule
